@@ hw/rtl/spf_pkg.sv @@
// -----------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the sensor packet framer modules.
// -----------------------------------------------------------------------------
package spf_pkg;

   localparam logic [7:0] MAX_PAYLOAD = 8'd128;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_kind;
      logic [7:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       end_of_packet;
   } rsp_type;

   // One classified request handed from front to back.
   typedef struct packed {
      logic       has_header;
      logic       has_hund;
      logic       has_tens;
      logic       has_data;
      logic       has_trailer;
      logic       kind;
      logic [1:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic [7:0] data;
      logic [7:0] checksum;
   } cmd_type;

   typedef enum logic [3:0] {
      STEP_COLON,
      STEP_KIND,
      STEP_FOUR,
      STEP_TWO,
      STEP_STAR_HDR,
      STEP_HUND,
      STEP_TENS,
      STEP_UNITS,
      STEP_STAR_LEN,
      STEP_DATA,
      STEP_STAR_TRL,
      STEP_SUM,
      STEP_SEMI
   } step_type;

endpackage

@@ hw/rtl/spf_front.sv @@
// -----------------------------------------------------------------------------
// spf_front
// Tracks packet state, classifies each request and builds its command.
// -----------------------------------------------------------------------------
module spf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  spf_pkg::req_type req,
   output spf_pkg::cmd_type cmd
);

   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  xor_ff, xor_in;
   logic        open_pkt;
   logic [7:0]  len_sat;
   logic [1:0]  hund;
   logic [7:0]  rest8;
   logic [6:0]  rest;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  units7;
   logic [7:0]  xor_next;

   assign open_pkt = (remaining_ff != 8'd0);
   assign len_sat  = (req.payload_length > spf_pkg::MAX_PAYLOAD) ?
                     spf_pkg::MAX_PAYLOAD : req.payload_length;

   // decimal digits: hundreds by compare, tens by reciprocal multiply
   always_comb begin
      priority if (len_sat >= 8'd200) begin
         hund = 2'd2;
      end else if (len_sat >= 8'd100) begin
         hund = 2'd1;
      end else begin
         hund = 2'd0;
      end
   end

   assign rest8     = len_sat - ((hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0);
   assign rest      = rest8[6:0];
   assign tens_prod = {8'd0, rest} * 15'd205;
   assign tens      = tens_prod[14:11];
   assign units7    = rest - ({3'd0, tens} * 7'd10);
   assign xor_next  = xor_ff ^ req.data_byte;

   always_comb begin
      cmd.kind  = req.packet_kind;
      cmd.data  = req.data_byte;
      cmd.hund  = hund;
      cmd.tens  = tens;
      cmd.units = units7[3:0];
      if (open_pkt) begin
         cmd.has_header  = 1'b0;
         cmd.has_hund    = 1'b0;
         cmd.has_tens    = 1'b0;
         cmd.has_data    = 1'b1;
         cmd.has_trailer = (remaining_ff == 8'd1);
         cmd.checksum    = xor_next;
         remaining_in    = remaining_ff - 8'd1;
         xor_in          = xor_next;
      end else begin
         cmd.has_header  = 1'b1;
         cmd.has_hund    = (len_sat >= 8'd100);
         cmd.has_tens    = (len_sat >= 8'd10);
         cmd.has_data    = (len_sat != 8'd0);
         cmd.has_trailer = (len_sat <= 8'd1);
         cmd.checksum    = (len_sat == 8'd0) ? 8'd0 : req.data_byte;
         remaining_in    = (len_sat == 8'd0) ? 8'd0 : len_sat - 8'd1;
         xor_in          = (len_sat == 8'd0) ? 8'd0 : req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 8'd0;
         xor_ff       <= 8'd0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
      end
   end

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff < spf_pkg::MAX_PAYLOAD)
      else $error("remaining count beyond maximum payload");

endmodule

@@ hw/rtl/spf_queue.sv @@
// -----------------------------------------------------------------------------
// spf_queue
// Small command queue between front and back.
// -----------------------------------------------------------------------------
module spf_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spf_pkg::cmd_type push_cmd,
   input  logic             pop,
   output spf_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   spf_pkg::cmd_type store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

endmodule

@@ hw/rtl/spf_back.sv @@
// -----------------------------------------------------------------------------
// spf_back
// Expands each command into framed bytes into an output stage, one per cycle while that stage is not held full.
// -----------------------------------------------------------------------------
module spf_back (
   input  logic             clock,
   input  logic             reset,
   input  spf_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output spf_pkg::rsp_type rsp_data
);

   spf_pkg::step_type step_ff, step_in, cur_step;
   logic              active_ff, active_in;
   logic              out_valid_ff, out_valid_in;
   spf_pkg::rsp_type  out_ff, out_in;
   logic              emit;
   logic              last_step;

   assign emit = !q_empty && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (active_ff) begin
         cur_step = step_ff;
      end else if (head.has_header) begin
         cur_step = spf_pkg::STEP_COLON;
      end else begin
         cur_step = spf_pkg::STEP_DATA;
      end
   end

   assign last_step = (cur_step == spf_pkg::STEP_SEMI) ||
                      ((cur_step == spf_pkg::STEP_DATA) && !head.has_trailer);

   always_comb begin
      step_in   = step_ff;
      active_in = active_ff;
      out_in    = out_ff;
      unique case (cur_step)
         spf_pkg::STEP_COLON: begin
            out_in.out_byte = spf_pkg::CHAR_COLON;
            step_in         = spf_pkg::STEP_KIND;
         end
         spf_pkg::STEP_KIND: begin
            out_in.out_byte = head.kind ? spf_pkg::CHAR_B : spf_pkg::CHAR_A;
            step_in         = spf_pkg::STEP_FOUR;
         end
         spf_pkg::STEP_FOUR: begin
            out_in.out_byte = spf_pkg::CHAR_FOUR;
            step_in         = spf_pkg::STEP_TWO;
         end
         spf_pkg::STEP_TWO: begin
            out_in.out_byte = spf_pkg::CHAR_TWO;
            step_in         = spf_pkg::STEP_STAR_HDR;
         end
         spf_pkg::STEP_STAR_HDR: begin
            out_in.out_byte = spf_pkg::CHAR_STAR;
            step_in         = head.has_hund ? spf_pkg::STEP_HUND :
                              head.has_tens ? spf_pkg::STEP_TENS : spf_pkg::STEP_UNITS;
         end
         spf_pkg::STEP_HUND: begin
            out_in.out_byte = spf_pkg::CHAR_ZERO | {6'd0, head.hund};
            step_in         = spf_pkg::STEP_TENS;
         end
         spf_pkg::STEP_TENS: begin
            out_in.out_byte = spf_pkg::CHAR_ZERO | {4'd0, head.tens};
            step_in         = spf_pkg::STEP_UNITS;
         end
         spf_pkg::STEP_UNITS: begin
            out_in.out_byte = spf_pkg::CHAR_ZERO | {4'd0, head.units};
            step_in         = spf_pkg::STEP_STAR_LEN;
         end
         spf_pkg::STEP_STAR_LEN: begin
            out_in.out_byte = spf_pkg::CHAR_STAR;
            step_in         = head.has_data ? spf_pkg::STEP_DATA : spf_pkg::STEP_STAR_TRL;
         end
         spf_pkg::STEP_DATA: begin
            out_in.out_byte = head.data;
            step_in         = spf_pkg::STEP_STAR_TRL;
         end
         spf_pkg::STEP_STAR_TRL: begin
            out_in.out_byte = spf_pkg::CHAR_STAR;
            step_in         = spf_pkg::STEP_SUM;
         end
         spf_pkg::STEP_SUM: begin
            out_in.out_byte = head.checksum;
            step_in         = spf_pkg::STEP_SEMI;
         end
         spf_pkg::STEP_SEMI: begin
            out_in.out_byte = spf_pkg::CHAR_SEMI;
            step_in         = spf_pkg::STEP_COLON;
         end
         default: begin
            out_in.out_byte = spf_pkg::CHAR_SEMI;
            step_in         = spf_pkg::STEP_COLON;
         end
      endcase
      out_in.end_of_run    = last_step;
      out_in.end_of_packet = (cur_step == spf_pkg::STEP_SEMI);
      if (emit) begin
         active_in = !last_step;
      end else begin
         step_in = step_ff;
         out_in  = out_ff;
      end
   end

   assign q_pop = emit && last_step;

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= spf_pkg::STEP_COLON;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_active_has_cmd: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !q_empty)
      else $error("expansion in progress without a queued command");

   a_eop_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.end_of_packet |-> out_ff.end_of_run)
      else $error("frame end not at end of run");

endmodule

@@ hw/rtl/sensor_packet_framer.sv @@
// -----------------------------------------------------------------------------
// sensor_packet_framer
// Frames sensor payload bytes into ':A42*'/':B42*' packets with length and
// XOR checksum for a serial link.
// -----------------------------------------------------------------------------
// Requests are classified by the front end in the cycle they are accepted and
// queued as commands (QUEUE_DEPTH entries); the back end turns each command
// into output bytes through a single output register, one byte per cycle while
// it is free or being popped. A middle payload request expands to one byte, the
// last one to four and the first one to up to eleven (seven to nine header and
// length bytes, then the payload byte, plus the trailer for a one-byte or empty
// packet). Request intake stalls only when the queue fills behind a long header
// burst or a stalled result side. Lengths above 128 are clamped to 128.
module sensor_packet_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  spf_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output spf_pkg::rsp_type rsp_data
);

   spf_pkg::cmd_type front_cmd;
   spf_pkg::cmd_type head_cmd;
   logic             accept;
   logic             q_empty;
   logic             q_pop;

   assign accept = req_push && !req_full;

   spf_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .cmd   (front_cmd)
   );

   spf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .push_cmd(front_cmd),
      .pop     (q_pop),
      .head    (head_cmd),
      .empty   (q_empty),
      .full    (req_full)
   );

   spf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_cmd),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule
